FILE: rtl/brb_pkg.sv
package brb_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 6;
  localparam int SUM_W = 7;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_RST  = 2'd3
  } cmd_t;

  typedef enum logic {
    JOB_STATUS = 1'b0,
    JOB_READ   = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic               ok;
    logic [PTR_W-1:0]   addr;
    logic [LEN_W-1:0]   len;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   free;
  } job_t;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] used_of(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
    logic [SUM_W-1:0] d;
    if (wp >= rp) begin
      d = SUM_W'(wp) - SUM_W'(rp);
    end else begin
      d = SUM_W'(wp) + SUM_W'(DEPTH) - SUM_W'(rp);
    end
    return d;
  endfunction

endpackage

FILE: rtl/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/brb_front.sv
module brb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 command,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic [brb_pkg::BYTE_W-1:0] data_byte,
  input  logic                       move_data,
  output logic                       busy,
  input  logic                       burst_end,
  input  logic                       q_full,
  output logic                       push,
  output brb_pkg::job_t              push_job,
  output logic                       ram_we,
  output logic [brb_pkg::PTR_W-1:0]  ram_waddr,
  output logic [brb_pkg::BYTE_W-1:0] ram_wdata
);

  localparam int PTR_W = brb_pkg::PTR_W;
  localparam int LEN_W = brb_pkg::LEN_W;
  localparam int SUM_W = brb_pkg::SUM_W;
  localparam int CNT_W = brb_pkg::CNT_W;

  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] pwp, pwp_next;
  logic [LEN_W-1:0] br, br_next;
  logic             enq_acc, enq_acc_next;
  logic             pending, pending_next;

  brb_pkg::cmd_t    cmd;
  logic             accept;
  logic [SUM_W-1:0] u;
  logic [SUM_W-1:0] u_after;
  logic             full;
  logic [LEN_W-1:0] br_eff;
  logic             acc_eff;
  logic [PTR_W-1:0] pwp_eff;

  function automatic brb_pkg::job_t make_job(input brb_pkg::job_kind_t kind,
                                             input logic ok,
                                             input logic [SUM_W-1:0] cnt);
    brb_pkg::job_t j;
    j = '0;
    j.kind = kind;
    j.ok = ok;
    j.used = CNT_W'(cnt);
    j.free = CNT_W'(SUM_W'(brb_pkg::DEPTH - 1) - cnt);
    return j;
  endfunction

  assign cmd    = brb_pkg::cmd_t'(command);
  assign busy   = pending || q_full;
  assign accept = start && !busy;
  assign u      = brb_pkg::used_of(wp, rp);
  assign full   = (u == SUM_W'(brb_pkg::DEPTH - 1));

  always_comb begin
    wp_next      = wp;
    rp_next      = rp;
    pwp_next     = pwp;
    br_next      = br;
    enq_acc_next = enq_acc;
    pending_next = pending;
    push         = 1'b0;
    push_job     = '0;
    ram_we       = 1'b0;
    ram_wdata    = data_byte;
    br_eff       = br;
    acc_eff      = enq_acc;
    pwp_eff      = pwp;
    ram_waddr    = pwp;
    u_after      = u;
    if (burst_end) begin
      pending_next = 1'b0;
    end
    if (accept) begin
      unique case (cmd)
        brb_pkg::CMD_ENQ: begin
          if (br == '0 && length == '0) begin
            push     = 1'b1;
            push_job = make_job(brb_pkg::JOB_STATUS, !full, u);
          end else begin
            if (br == '0) begin
              acc_eff = !full && (SUM_W'(brb_pkg::DEPTH - 1) - u >= SUM_W'(length));
              pwp_eff = wp;
              br_eff  = length;
            end
            ram_waddr = pwp_eff;
            if (acc_eff) begin
              ram_we  = move_data;
              pwp_eff = brb_pkg::ptr_add(pwp_eff, LEN_W'(1));
            end
            br_next      = br_eff - LEN_W'(1);
            enq_acc_next = acc_eff;
            pwp_next     = pwp_eff;
            if (br_next == '0) begin
              enq_acc_next = 1'b0;
              if (acc_eff) begin
                wp_next = pwp_eff;
              end
              push     = 1'b1;
              push_job = make_job(brb_pkg::JOB_STATUS, acc_eff,
                                  brb_pkg::used_of(wp_next, rp));
            end
          end
        end
        brb_pkg::CMD_RST: begin
          br_next      = '0;
          enq_acc_next = 1'b0;
          wp_next      = '0;
          rp_next      = '0;
          pwp_next     = '0;
          push         = 1'b1;
          push_job     = make_job(brb_pkg::JOB_STATUS, 1'b1, '0);
        end
        brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
          br_next      = '0;
          enq_acc_next = 1'b0;
          pwp_next     = wp;
          push         = 1'b1;
          if (u == '0 || u < SUM_W'(length)) begin
            push_job = make_job(brb_pkg::JOB_STATUS, 1'b0, u);
          end else begin
            if (cmd == brb_pkg::CMD_DEQ) begin
              rp_next = brb_pkg::ptr_add(rp, length);
              u_after = u - SUM_W'(length);
            end
            if (length == '0 || !move_data) begin
              push_job = make_job(brb_pkg::JOB_STATUS, 1'b1, u_after);
            end else begin
              push_job      = make_job(brb_pkg::JOB_READ, 1'b1, u_after);
              push_job.addr = rp;
              push_job.len  = length;
              pending_next  = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      pwp     <= '0;
      br      <= '0;
      enq_acc <= 1'b0;
      pending <= 1'b0;
    end else begin
      wp      <= wp_next;
      rp      <= rp_next;
      pwp     <= pwp_next;
      br      <= br_next;
      enq_acc <= enq_acc_next;
      pending <= pending_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("Job pushed into a full queue.");
  a_acc_in_run: assert property (@(posedge clk) disable iff (rst) enq_acc |-> br != '0)
    else $error("Enqueue run marked accepted with no beats left.");
  a_ptr_reset: assert property (@(posedge clk) disable iff (rst)
      (accept && cmd == brb_pkg::CMD_RST) |=> (wp == '0 && rp == '0 && br == '0))
    else $error("Pointer reset did not clear the pointers.");
`endif

endmodule

FILE: rtl/brb_queue.sv
module brb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brb_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output brb_pkg::job_t q_job
);

  localparam int Q_DEPTH = brb_pkg::Q_DEPTH;
  localparam int Q_PTR_W = brb_pkg::Q_PTR_W;

  brb_pkg::job_t      entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign q_job   = entries[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (Q_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (Q_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/brb_back.sv
module brb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  brb_pkg::job_t              q_job,
  output logic                       pop,
  output logic                       burst_end,
  output logic [brb_pkg::PTR_W-1:0]  ram_raddr,
  input  logic [brb_pkg::BYTE_W-1:0] ram_rdata,
  output logic                       strobe,
  output logic [brb_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic                       ok,
  output logic                       last,
  output logic [brb_pkg::CNT_W-1:0]  used_count,
  output logic [brb_pkg::CNT_W-1:0]  free_count
);

  localparam int LEN_W = brb_pkg::LEN_W;

  logic          active;
  brb_pkg::job_t cur;
  logic          finishing;

  assign finishing = active && (cur.kind == brb_pkg::JOB_STATUS || cur.len == LEN_W'(1));
  assign burst_end = active && cur.kind == brb_pkg::JOB_READ && cur.len == LEN_W'(1);
  assign pop       = q_valid && (!active || finishing);
  assign ram_raddr = cur.addr;
  assign out_byte  = byte_valid ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      byte_valid <= (cur.kind == brb_pkg::JOB_READ);
      ok         <= cur.ok;
      last       <= finishing;
      used_count <= cur.used;
      free_count <= cur.free;
    end
    if (pop) begin
      cur <= q_job;
    end else if (active) begin
      cur.addr <= brb_pkg::ptr_add(cur.addr, LEN_W'(1));
      cur.len  <= cur.len - LEN_W'(1);
    end
  end

endmodule

FILE: rtl/byte_ring_buffer_transactions.sv
// Byte ring buffer with all-or-nothing transfers.
// Input channel: an item (command, length, data_byte, move_data) is taken at
// a rising edge where start is high and busy is low. Enqueue runs send one
// byte beat per cycle; dequeue, peek and pointer reset are single items.
// Result channel: each result is valid for exactly one cycle while strobe is
// high, and the receiver must take it in that cycle.
// A status result passes through the job queue, the back section's job
// register and the result registers before it is on the result ports. A
// dequeue or peek with data streams its bytes one per cycle.
// Enqueue beats and status items are taken one per cycle while busy is low.
// During a read burst, busy stays high until the last byte has been read
// from the byte memory, so the next item is taken only after that read.
// The front section classifies items and owns the pointers, a two-entry job
// queue buffers its decisions, and the back section reads the memory and
// drives the result ports.
// Reset clears the pointers, the open enqueue run and the job queue; memory
// contents are not cleared, and no result follows reset.
module byte_ring_buffer_transactions (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic [brb_pkg::BYTE_W-1:0] data_byte,
  input  logic                       move_data,
  output logic                       strobe,
  output logic [brb_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic                       ok,
  output logic                       last,
  output logic [brb_pkg::CNT_W-1:0]  used_count,
  output logic [brb_pkg::CNT_W-1:0]  free_count
);

  logic                       burst_end;
  logic                       q_full;
  logic                       q_valid;
  logic                       push;
  logic                       pop;
  brb_pkg::job_t              push_job;
  brb_pkg::job_t              q_job;
  logic                       ram_we;
  logic [brb_pkg::PTR_W-1:0]  ram_waddr;
  logic [brb_pkg::BYTE_W-1:0] ram_wdata;
  logic [brb_pkg::PTR_W-1:0]  ram_raddr;
  logic [brb_pkg::BYTE_W-1:0] ram_rdata;

  brb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .length    (length),
    .data_byte (data_byte),
    .move_data (move_data),
    .busy      (busy),
    .burst_end (burst_end),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  brb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .burst_end  (burst_end),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .ok         (ok),
    .last       (last),
    .used_count (used_count),
    .free_count (free_count)
  );

endmodule

FILE: verif/byte_ring_buffer_transactions_tb.sv
module byte_ring_buffer_transactions_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = brb_pkg::DEPTH;
  localparam int PTR_W = brb_pkg::PTR_W;
  localparam int LEN_W = brb_pkg::LEN_W;
  localparam int BYTE_W = brb_pkg::BYTE_W;
  localparam int CNT_W = brb_pkg::CNT_W;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 16;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_data;
    logic              granted;
    logic              closing;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  room;
  } ring_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command = brb_pkg::CMD_ENQ;
  logic [LEN_W-1:0]  length = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              move_data = 1'b0;
  logic              strobe;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              ok;
  logic              last;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  free_count;

  ring_reply_t       awaited_replies[$];
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  bit                ring_written [DEPTH];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic [PTR_W-1:0]  run_ptr = '0;
  logic [LEN_W-1:0]  beats_left = '0;
  logic              run_ok = 1'b0;

  int error_count = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int bytes_seen = 0;
  int stall_cycles = 0;
  int burst_left = 0;

  byte_ring_buffer_transactions dut (.*);

  always #6 clk = ~clk;

  function automatic logic [CNT_W-1:0] fill_level();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic bit cells_known(logic [LEN_W-1:0] len);
    int k;
    for (k = 0; k < len; k++) begin
      if (!ring_written[rd_ptr + PTR_W'(k)]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic push_reply(logic [BYTE_W-1:0] data, logic has_data, logic granted,
                            logic closing);
    ring_reply_t r;
    r.data = data;
    r.has_data = has_data;
    r.granted = granted;
    r.closing = closing;
    r.used = fill_level();
    r.room = CNT_W'(DEPTH - 1) - r.used;
    awaited_replies.push_back(r);
  endtask

  task automatic predict_ring_item(brb_pkg::cmd_t c, logic [LEN_W-1:0] len,
                                   logic [BYTE_W-1:0] db, logic mv);
    logic [CNT_W-1:0] fill;
    logic [PTR_W-1:0] base;
    int k;
    if (c == brb_pkg::CMD_ENQ) begin
      if (beats_left == 0) begin
        fill = fill_level();
        if (len == 0) begin
          push_reply('0, 1'b0, fill != CNT_W'(DEPTH - 1), 1'b1);
          return;
        end
        run_ok = (fill != CNT_W'(DEPTH - 1)) && ((CNT_W'(DEPTH - 1) - fill) >= len);
        run_ptr = wr_ptr;
        beats_left = len;
      end
      if (run_ok) begin
        if (mv) begin
          ring_mem[run_ptr] = db;
          ring_written[run_ptr] = 1'b1;
        end
        run_ptr = run_ptr + 1'b1;
      end
      beats_left = beats_left - 1'b1;
      if (beats_left == 0) begin
        if (run_ok) begin
          wr_ptr = run_ptr;
        end
        push_reply('0, 1'b0, run_ok, 1'b1);
        run_ok = 1'b0;
      end
      return;
    end
    beats_left = '0;
    run_ok = 1'b0;
    run_ptr = wr_ptr;
    if (c == brb_pkg::CMD_RST) begin
      wr_ptr = '0;
      rd_ptr = '0;
      run_ptr = '0;
      push_reply('0, 1'b0, 1'b1, 1'b1);
      return;
    end
    fill = fill_level();
    if (fill == 0 || fill < len) begin
      push_reply('0, 1'b0, 1'b0, 1'b1);
      return;
    end
    base = rd_ptr;
    if (c == brb_pkg::CMD_DEQ) begin
      rd_ptr = rd_ptr + len;
    end
    if (len == 0 || !mv) begin
      push_reply('0, 1'b0, 1'b1, 1'b1);
      return;
    end
    for (k = 0; k < len; k++) begin
      push_reply(ring_mem[base + PTR_W'(k)], 1'b1, 1'b1, k == len - 1);
    end
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      command <= 2'($urandom);
      length <= LEN_W'($urandom);
      data_byte <= BYTE_W'($urandom);
      move_data <= 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic transfer_item(brb_pkg::cmd_t c, logic [LEN_W-1:0] len,
                               logic [BYTE_W-1:0] db, logic mv);
    if (burst_left == 0) begin
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    command <= c;
    length <= len;
    data_byte <= db;
    move_data <= mv;
    do @(posedge clk); while (busy);
    predict_ring_item(c, len, db, mv);
    items_sent++;
  endtask

  task automatic drain_replies();
    hold_off(1);
    while (awaited_replies.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic enqueue_run(logic [LEN_W-1:0] len, int beats, int skip_pct);
    int b;
    for (b = 0; b < beats; b++) begin
      transfer_item(brb_pkg::CMD_ENQ, (b == 0) ? len : LEN_W'($urandom), BYTE_W'($urandom),
                    $urandom_range(0, 99) >= skip_pct);
    end
  endtask

  task automatic random_read(brb_pkg::cmd_t c);
    logic [CNT_W-1:0] fill;
    logic [LEN_W-1:0] len;
    logic mv;
    int pick;
    fill = fill_level();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      len = '0;
    end else if (pick == 1 || fill == 0) begin
      len = LEN_W'($urandom_range(0, 63));
    end else begin
      len = LEN_W'($urandom_range(1, (fill < 16) ? fill : 16));
    end
    mv = ($urandom_range(0, 6) != 0);
    if (mv && fill != 0 && fill >= len && !cells_known(len)) begin
      mv = 1'b0;
    end
    transfer_item(c, len, BYTE_W'($urandom), mv);
  endtask

  task automatic random_enqueue();
    logic [CNT_W-1:0] room;
    logic [LEN_W-1:0] len;
    int pick;
    int beats;
    room = CNT_W'(DEPTH - 1) - fill_level();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      len = '0;
    end else if (pick == 1 && room < CNT_W'(DEPTH - 1)) begin
      len = (room > 60) ? LEN_W'(63) : LEN_W'(room + 1 + $urandom_range(0, 2));
    end else begin
      len = LEN_W'($urandom_range(1, 8));
    end
    beats = (len == 0) ? 1 : len;
    if (beats > 1 && $urandom_range(0, 7) == 0) begin
      enqueue_run(len, $urandom_range(1, beats - 1), 10);
      if ($urandom_range(0, 3) == 0) begin
        transfer_item(brb_pkg::CMD_RST, LEN_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      end else begin
        random_read(($urandom_range(0, 1) == 0) ? brb_pkg::CMD_DEQ : brb_pkg::CMD_PEEK);
      end
    end else begin
      enqueue_run(len, beats, 10);
    end
  endtask

  task automatic test_empty_buffer();
    transfer_item(brb_pkg::CMD_DEQ, 6'd5, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_PEEK, 6'd0, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'd0, 8'hff, 1'b1);
    transfer_item(brb_pkg::CMD_RST, 6'h3f, 8'h00, 1'b0);
  endtask

  task automatic test_basic_transfers();
    transfer_item(brb_pkg::CMD_ENQ, 6'd4, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'd0, 8'hff, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'h3f, 8'ha5, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'd0, 8'h5a, 1'b1);
    transfer_item(brb_pkg::CMD_PEEK, 6'd4, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_PEEK, 6'd0, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd5, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd2, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd2, 8'h00, 1'b0);
    // Pointers advance over these beats without anything being stored.
    transfer_item(brb_pkg::CMD_ENQ, 6'd3, 8'h33, 1'b0);
    transfer_item(brb_pkg::CMD_ENQ, 6'd3, 8'h44, 1'b0);
    transfer_item(brb_pkg::CMD_ENQ, 6'd3, 8'h55, 1'b0);
    transfer_item(brb_pkg::CMD_DEQ, 6'd3, 8'h00, 1'b0);
  endtask

  task automatic test_abandoned_runs();
    transfer_item(brb_pkg::CMD_ENQ, 6'd6, 8'h11, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'd6, 8'h22, 1'b1);
    transfer_item(brb_pkg::CMD_PEEK, 6'd1, 8'h00, 1'b1);
    enqueue_run(6'd2, 2, 0);
    transfer_item(brb_pkg::CMD_ENQ, 6'd4, 8'h66, 1'b1);
    transfer_item(brb_pkg::CMD_RST, 6'd0, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd1, 8'h00, 1'b1);
  endtask

  task automatic test_full_buffer();
    enqueue_run(6'd63, 63, 0);
    transfer_item(brb_pkg::CMD_ENQ, 6'd1, 8'h77, 1'b1);
    transfer_item(brb_pkg::CMD_ENQ, 6'd0, 8'h77, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd1, 8'h00, 1'b1);
    enqueue_run(6'd2, 2, 0);
    enqueue_run(6'd1, 1, 0);
    transfer_item(brb_pkg::CMD_PEEK, 6'd63, 8'h00, 1'b1);
    transfer_item(brb_pkg::CMD_DEQ, 6'd63, 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        random_enqueue();
      end else if (pick < 72) begin
        random_read(brb_pkg::CMD_DEQ);
      end else if (pick < 95) begin
        random_read(brb_pkg::CMD_PEEK);
      end else begin
        transfer_item(brb_pkg::CMD_RST, LEN_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 29) == 0) begin
        drain_replies();
      end
    end
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] expected,
                             logic [BYTE_W-1:0] actual);
    if (actual !== expected) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    ring_reply_t want;
    if (!rst && strobe) begin
      replies_seen++;
      if (byte_valid === 1'b1) begin
        bytes_seen++;
      end
      if (awaited_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transfer, out_byte %0h ok %0b last %0b",
                 $time, out_byte, ok, last);
      end else begin
        want = awaited_replies.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("byte_valid", BYTE_W'(want.has_data), BYTE_W'(byte_valid));
        check_field("ok", BYTE_W'(want.granted), BYTE_W'(ok));
        check_field("last", BYTE_W'(want.closing), BYTE_W'(last));
        check_field("used_count", BYTE_W'(want.used), BYTE_W'(used_count));
        check_field("free_count", BYTE_W'(want.room), BYTE_W'(free_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_buffer();
    drain_replies();
    test_basic_transfers();
    drain_replies();
    test_abandoned_runs();
    drain_replies();
    test_full_buffer();
    drain_replies();
    test_random_traffic();
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d input transfers and checked %0d result transfers (%0d data bytes).",
             items_sent, replies_seen, bytes_seen);
    $display("Covered empty and full buffer, refused and abandoned runs, pointer reset, wrap.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
